// File: src/cpt_pkg.sv
package cpt_pkg;

    // coordinate and internal widths
    localparam int CW   = 32;            // coordinate width
    localparam int DW   = CW + 1;        // vertex difference
    localparam int PW   = 2 * DW;        // difference product
    localparam int DOTW = PW + 2;        // dot product
    localparam int WW   = 2 * DOTW;      // product of two dots
    localparam int VW   = WW + 1;        // barycentric numerators
    localparam int NW   = DW + VW + 1;   // placement numerator / divisor
    localparam int QW   = CW + 2;        // quotient bits kept
    localparam int RW   = NW + QW + 1;   // divider remainder
    localparam int SW   = QW + 2;        // final signed sum

    // chunk widths for the split wide products
    localparam int DC   = 23;            // dot operand chunk (3 chunks)
    localparam int WC   = 28;            // weight operand chunk (5 chunks)

    localparam logic [2:0] RG_VERT_A = 3'd0;
    localparam logic [2:0] RG_VERT_B = 3'd1;
    localparam logic [2:0] RG_EDGE_AB = 3'd2;
    localparam logic [2:0] RG_VERT_C = 3'd3;
    localparam logic [2:0] RG_EDGE_AC = 3'd4;
    localparam logic [2:0] RG_EDGE_BC = 3'd5;
    localparam logic [2:0] RG_FACE = 3'd6;

    typedef logic signed [CW-1:0]   t_coord;
    typedef logic signed [DW-1:0]   t_diff;
    typedef logic signed [PW-1:0]   t_prod;
    typedef logic signed [DOTW-1:0] t_dot;
    typedef logic signed [WW-1:0]   t_wide;
    typedef logic signed [VW-1:0]   t_v;
    typedef logic signed [NW-1:0]   t_num;
    typedef logic [RW-1:0]          t_rem;
    typedef logic signed [SW-1:0]   t_sum;
    typedef logic signed [2*DC+1:0] t_dpp;   // dot chunk partial product
    typedef logic signed [DW+WC:0]  t_wpp;   // vector x weight chunk partial

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
        t_coord vert_a_x;
        t_coord vert_a_y;
        t_coord vert_a_z;
        t_coord vert_b_x;
        t_coord vert_b_y;
        t_coord vert_b_z;
        t_coord vert_c_x;
        t_coord vert_c_y;
        t_coord vert_c_z;
    } t_in;

    typedef struct packed {
        t_coord     near_x;
        t_coord     near_y;
        t_coord     near_z;
        logic [2:0] region;
    } t_out;

    typedef t_dot [5:0] t_dots;

    typedef struct packed {
        t_coord [2:0] a;
        t_coord [2:0] b;
        t_coord [2:0] c;
        t_diff [2:0]  ab;
        t_diff [2:0]  ac;
        t_diff [2:0]  bc;
    } t_geo;

    // divider job: magnitudes already prepared for round-half-away
    typedef struct packed {
        t_rem [2:0]   nn;
        logic [2:0]   neg;
        t_rem         dd;
        logic         dz;
        t_coord [2:0] base;
        logic [2:0]   region;
    } t_job;

    typedef struct packed {
        t_rem [2:0]          rem;
        logic [2:0][QW-1:0]  q;
        logic [2:0]          ovf;
        logic [2:0]          neg;
        t_rem                dd;
        logic                dz;
        t_coord [2:0]        base;
        logic [2:0]          region;
    } t_dv;

    function automatic t_diff sub_ext(t_coord x, t_coord y);
        return t_diff'(x) - t_diff'(y);
    endfunction

    // dot chunk i: low chunks unsigned, top chunk carries the sign
    function automatic logic signed [DC:0] dchunk(t_dot d, int i);
        if (i == 2) return (DC+1)'($signed(d[DOTW-1:2*DC]));
        return {1'b0, d[i*DC +: DC]};
    endfunction

    // weight chunk i: low chunks unsigned, top chunk carries the sign
    function automatic logic signed [WC:0] wchunk(t_v v, int i);
        if (i == 4) return (WC+1)'($signed(v[VW-1:4*WC]));
        return {1'b0, v[i*WC +: WC]};
    endfunction

endpackage

// File: src/cpt_front.sv
// Differences, difference products, dot products: three stages.
module cpt_front import cpt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_in   i_data,
    output logic  o_valid,
    output t_geo  o_geo,
    output t_dots o_dot
);

    t_coord [2:0] n_p, n_a, n_b, n_c;
    t_geo         n_s1_geo, r_s1_geo, r_s2_geo, r_s3_geo;
    t_diff [2:0]  n_s1_ap, n_s1_bp, n_s1_cp, r_s1_ap, r_s1_bp, r_s1_cp;
    t_prod [5:0][2:0] n_s2_prod, r_s2_prod;
    t_dots        n_s3_dot, r_s3_dot;
    logic         r_s1_valid, r_s2_valid, r_s3_valid;

    always_comb begin
        n_p = {i_data.point_z, i_data.point_y, i_data.point_x};
        n_a = {i_data.vert_a_z, i_data.vert_a_y, i_data.vert_a_x};
        n_b = {i_data.vert_b_z, i_data.vert_b_y, i_data.vert_b_x};
        n_c = {i_data.vert_c_z, i_data.vert_c_y, i_data.vert_c_x};
        n_s1_geo.a = n_a;
        n_s1_geo.b = n_b;
        n_s1_geo.c = n_c;
        for (int k = 0; k < 3; k++) begin
            n_s1_geo.ab[k] = sub_ext(n_b[k], n_a[k]);
            n_s1_geo.ac[k] = sub_ext(n_c[k], n_a[k]);
            n_s1_geo.bc[k] = sub_ext(n_c[k], n_b[k]);
            n_s1_ap[k]     = sub_ext(n_p[k], n_a[k]);
            n_s1_bp[k]     = sub_ext(n_p[k], n_b[k]);
            n_s1_cp[k]     = sub_ext(n_p[k], n_c[k]);
        end
    end

    // d1=ab.ap d2=ac.ap d3=ab.bp d4=ac.bp d5=ab.cp d6=ac.cp
    always_comb begin
        t_diff u;
        t_diff v;
        for (int j = 0; j < 6; j++) begin
            for (int k = 0; k < 3; k++) begin
                u = (j % 2 == 0) ? r_s1_geo.ab[k] : r_s1_geo.ac[k];
                v = (j < 2) ? r_s1_ap[k] : ((j < 4) ? r_s1_bp[k] : r_s1_cp[k]);
                n_s2_prod[j][k] = t_prod'(u) * t_prod'(v);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            n_s3_dot[j] = t_dot'($signed(r_s2_prod[j][0]))
                        + t_dot'($signed(r_s2_prod[j][1]))
                        + t_dot'($signed(r_s2_prod[j][2]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_geo  <= n_s1_geo;
            r_s1_ap   <= n_s1_ap;
            r_s1_bp   <= n_s1_bp;
            r_s1_cp   <= n_s1_cp;
            r_s2_geo  <= r_s1_geo;
            r_s2_prod <= n_s2_prod;
            r_s3_geo  <= r_s2_geo;
            r_s3_dot  <= n_s3_dot;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_geo   = r_s3_geo;
    assign o_dot   = r_s3_dot;

endmodule

// File: src/cpt_sel.sv
// Region tests and placement numerator: six stages. Wide products are
// split into narrow partial products and summed one stage later.
module cpt_sel import cpt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_geo  i_geo,
    input  t_dots i_dot,
    output logic  o_valid,
    output t_job  o_job
);

    // stage 4: partial products of dot pairs
    t_dots                n_s4_x, n_s4_y;
    t_dpp [5:0][2:0][2:0] n_s4_pp, r_s4_pp;
    t_dots                r_s4_dot;
    t_geo                 r_s4_geo;
    logic                 r_s4_valid;

    // pairs: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
    always_comb begin
        n_s4_x = {i_dot[4], i_dot[2], i_dot[0], i_dot[4], i_dot[2], i_dot[0]};
        n_s4_y = {i_dot[3], i_dot[5], i_dot[5], i_dot[1], i_dot[1], i_dot[3]};
        for (int j = 0; j < 6; j++) begin
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    n_s4_pp[j][a][b] = dchunk(n_s4_x[j], a) * dchunk(n_s4_y[j], b);
                end
            end
        end
    end

    // stage 5: sum partials into the dot pair products
    t_wide [5:0] n_s5_pv, r_s5_pv;
    t_dots       r_s5_dot;
    t_geo        r_s5_geo;
    logic        r_s5_valid;

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            n_s5_pv[j] = '0;
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    n_s5_pv[j] = n_s5_pv[j]
                               + (t_wide'($signed(r_s4_pp[j][a][b])) <<< (DC * (a + b)));
                end
            end
        end
    end

    // stage 6: classify and pick operands
    t_diff [2:0]  n_s6_vec1, n_s6_vec2, r_s6_vec1, r_s6_vec2;
    t_v           n_s6_s1, n_s6_s2, r_s6_s1, r_s6_s2;
    t_num         n_s6_den, r_s6_den;
    t_coord [2:0] n_s6_base, r_s6_base;
    logic [2:0]   n_s6_region, r_s6_region;
    logic         r_s6_valid;

    always_comb begin
        t_dot d1, d2, d3, d4, d5, d6;
        t_v   vc, vb, va, e1, e2;
        d1 = r_s5_dot[0];
        d2 = r_s5_dot[1];
        d3 = r_s5_dot[2];
        d4 = r_s5_dot[3];
        d5 = r_s5_dot[4];
        d6 = r_s5_dot[5];
        vc = t_v'($signed(r_s5_pv[0])) - t_v'($signed(r_s5_pv[1]));
        vb = t_v'($signed(r_s5_pv[2])) - t_v'($signed(r_s5_pv[3]));
        va = t_v'($signed(r_s5_pv[4])) - t_v'($signed(r_s5_pv[5]));
        e1 = t_v'(d4) - t_v'(d3);
        e2 = t_v'(d5) - t_v'(d6);
        n_s6_vec1   = r_s5_geo.ab;
        n_s6_vec2   = r_s5_geo.ac;
        n_s6_s1     = '0;
        n_s6_s2     = '0;
        n_s6_den    = '0;
        n_s6_base   = r_s5_geo.a;
        n_s6_region = RG_FACE;
        if (d1 <= 0 && d2 <= 0) begin
            n_s6_region = RG_VERT_A;
        end else if (d3 >= 0 && d3 >= d4) begin
            n_s6_region = RG_VERT_B;
            n_s6_base   = r_s5_geo.b;
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            n_s6_region = RG_EDGE_AB;
            n_s6_s1     = t_v'(d1);
            n_s6_den    = t_num'(d1) - t_num'(d3);
        end else if (d6 >= 0 && d6 >= d5) begin
            n_s6_region = RG_VERT_C;
            n_s6_base   = r_s5_geo.c;
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            n_s6_region = RG_EDGE_AC;
            n_s6_vec1   = r_s5_geo.ac;
            n_s6_s1     = t_v'(d2);
            n_s6_den    = t_num'(d2) - t_num'(d6);
        end else if (va <= 0 && e1 >= 0 && e2 >= 0) begin
            n_s6_region = RG_EDGE_BC;
            n_s6_vec1   = r_s5_geo.bc;
            n_s6_s1     = e1;
            n_s6_den    = t_num'(e1) + t_num'(e2);
            n_s6_base   = r_s5_geo.b;
        end else begin
            n_s6_s1  = vb;
            n_s6_s2  = vc;
            n_s6_den = t_num'(va) + t_num'(vb) + t_num'(vc);
        end
    end

    // stage 7: vector times weight chunks
    t_wpp [2:0][4:0] n_s7_p1, n_s7_p2, r_s7_p1, r_s7_p2;
    t_num            r_s7_den;
    t_coord [2:0]    r_s7_base;
    logic [2:0]      r_s7_region;
    logic            r_s7_valid;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 5; i++) begin
                n_s7_p1[k][i] = $signed(r_s6_vec1[k]) * wchunk(r_s6_s1, i);
                n_s7_p2[k][i] = $signed(r_s6_vec2[k]) * wchunk(r_s6_s2, i);
            end
        end
    end

    // stage 8: sum weight partials
    t_num [2:0]   n_s8_m1, n_s8_m2, r_s8_m1, r_s8_m2;
    t_num         r_s8_den;
    t_coord [2:0] r_s8_base;
    logic [2:0]   r_s8_region;
    logic         r_s8_valid;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s8_m1[k] = '0;
            n_s8_m2[k] = '0;
            for (int i = 0; i < 5; i++) begin
                n_s8_m1[k] = n_s8_m1[k] + (t_num'($signed(r_s7_p1[k][i])) <<< (WC * i));
                n_s8_m2[k] = n_s8_m2[k] + (t_num'($signed(r_s7_p2[k][i])) <<< (WC * i));
            end
        end
    end

    // stage 9: numerator, signs, magnitudes for rounded division
    t_job n_s9_job, r_s9_job;
    logic r_s9_valid;

    always_comb begin
        t_num num, nm, dm;
        dm = r_s8_den[NW-1] ? -r_s8_den : r_s8_den;
        n_s9_job.dd     = t_rem'(dm) << 1;
        n_s9_job.dz     = (r_s8_den == '0);
        n_s9_job.base   = r_s8_base;
        n_s9_job.region = r_s8_region;
        for (int k = 0; k < 3; k++) begin
            num = $signed(r_s8_m1[k]) + $signed(r_s8_m2[k]);
            nm  = num[NW-1] ? -num : num;
            n_s9_job.neg[k] = num[NW-1] ^ r_s8_den[NW-1];
            n_s9_job.nn[k]  = (t_rem'(nm) << 1) + t_rem'(dm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
            r_s8_valid <= 1'b0;
            r_s9_valid <= 1'b0;
        end else if (i_en) begin
            r_s4_valid <= i_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
            r_s7_valid <= r_s6_valid;
            r_s8_valid <= r_s7_valid;
            r_s9_valid <= r_s8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_pp     <= n_s4_pp;
            r_s4_dot    <= i_dot;
            r_s4_geo    <= i_geo;
            r_s5_pv     <= n_s5_pv;
            r_s5_dot    <= r_s4_dot;
            r_s5_geo    <= r_s4_geo;
            r_s6_vec1   <= n_s6_vec1;
            r_s6_vec2   <= n_s6_vec2;
            r_s6_s1     <= n_s6_s1;
            r_s6_s2     <= n_s6_s2;
            r_s6_den    <= n_s6_den;
            r_s6_base   <= n_s6_base;
            r_s6_region <= n_s6_region;
            r_s7_p1     <= n_s7_p1;
            r_s7_p2     <= n_s7_p2;
            r_s7_den    <= r_s6_den;
            r_s7_base   <= r_s6_base;
            r_s7_region <= r_s6_region;
            r_s8_m1     <= n_s8_m1;
            r_s8_m2     <= n_s8_m2;
            r_s8_den    <= r_s7_den;
            r_s8_base   <= r_s7_base;
            r_s8_region <= r_s7_region;
            r_s9_job    <= n_s9_job;
        end
    end

    assign o_valid = r_s9_valid;
    assign o_job   = r_s9_job;

endmodule

// File: src/cpt_div.sv
// Restoring divider, one quotient bit per stage; stage 0 flags quotient overflow.
module cpt_div import cpt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_job i_job,
    output logic o_valid,
    output t_dv  o_st
);

    t_dv       n_st [0:QW];
    t_dv       r_st [0:QW];
    logic [QW:0] r_v;

    always_comb begin
        t_rem lim;
        t_rem sh;
        lim = i_job.dd << QW;
        n_st[0].rem    = i_job.nn;
        n_st[0].q      = '0;
        n_st[0].neg    = i_job.neg;
        n_st[0].dd     = i_job.dd;
        n_st[0].dz     = i_job.dz;
        n_st[0].base   = i_job.base;
        n_st[0].region = i_job.region;
        for (int k = 0; k < 3; k++) begin
            n_st[0].ovf[k] = (i_job.nn[k] >= lim);
        end
        for (int s = 1; s <= QW; s++) begin
            n_st[s] = r_st[s-1];
            sh = r_st[s-1].dd << (QW - s);
            for (int k = 0; k < 3; k++) begin
                if (r_st[s-1].rem[k] >= sh) begin
                    n_st[s].rem[k]        = r_st[s-1].rem[k] - sh;
                    n_st[s].q[k][QW - s]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s <= QW; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_st    = r_st[QW];

endmodule

// File: src/closest_point_on_triangle.sv
// Pipeline registers from input transfer to output valid: 3 front, 6 select,
// 35 divider, 1 output register.
// Throughput: one transfer per cycle; the whole pipeline moves together and
// holds only while a finished result waits under i_stall.
// Reset (i_rst_n low, synchronous): all stage valid bits and the output
// valid clear; data registers are not reset.
module closest_point_on_triangle import cpt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam t_coord C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord C_MIN = {1'b1, {(CW-1){1'b0}}};

    // Single pipeline advance: every stage moves when the output register
    // is empty or its contents are being taken this cycle.
    logic  w_en;
    logic  w_fr_valid, w_sel_valid, w_div_valid;
    t_geo  w_geo;
    t_dots w_dot;
    t_job  w_job;
    t_dv   w_st;
    t_out  n_out, r_out;
    logic  r_out_valid;

    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = !w_en;

    // P-A, P-B, P-C and edge vectors, then the six dot products
    cpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (w_fr_valid),
        .o_geo   (w_geo),
        .o_dot   (w_dot)
    );

    // Voronoi region tests; builds numerator/divisor of the placement
    cpt_sel u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_valid),
        .i_geo   (w_geo),
        .i_dot   (w_dot),
        .o_valid (w_sel_valid),
        .o_job   (w_job)
    );

    // Rounded quotient for all three coordinates in parallel
    cpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sel_valid),
        .i_job   (w_job),
        .o_valid (w_div_valid),
        .o_st    (w_st)
    );

    // base + signed quotient, then clamp to the coordinate range.
    // Zero divisor (vertex regions, degenerate triangle) gives the base.
    always_comb begin
        t_sum         qs;
        t_sum         v;
        t_coord [2:0] nr;
        for (int k = 0; k < 3; k++) begin
            qs = t_sum'({2'b00, w_st.q[k]});
            if (w_st.neg[k]) begin
                qs = -qs;
            end
            v = t_sum'(w_st.base[k]) + qs;
            if (w_st.dz) begin
                nr[k] = w_st.base[k];
            end else if (w_st.ovf[k]) begin
                nr[k] = w_st.neg[k] ? C_MIN : C_MAX;
            end else if (v > t_sum'(C_MAX)) begin
                nr[k] = C_MAX;
            end else if (v < t_sum'(C_MIN)) begin
                nr[k] = C_MIN;
            end else begin
                nr[k] = v[CW-1:0];
            end
        end
        n_out.near_x = nr[0];
        n_out.near_y = nr[1];
        n_out.near_z = nr[2];
        n_out.region = w_st.region;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
